// ----- hdl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants and types of the brake pressure conditioner.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;
  localparam int FILT_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int ALPHA_W     = FRAC_BITS + 1;
  localparam int FSP_W       = 16;
  localparam int PCT_W       = 7;
  localparam int PRES_W      = FSP_W;

  localparam int MUL_A_W     = FILT_W + 1;
  localparam int MUL_B_W     = ALPHA_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam int QUO_W       = PRES_W;
  localparam int NARROW_BITS = PCT_W;
  localparam int DVD_W       = FILT_W + QUO_W;
  localparam int REM_W       = FILT_W + 1;
  localparam int CNT_W       = $clog2(QUO_W + 1);

  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [ALPHA_W-1:0]     ALPHA_ONE = ALPHA_W'(1 << FRAC_BITS);
  localparam logic [SAMPLE_BITS-1:0] ADC_LIMIT = SAMPLE_BITS'(4095);
  localparam logic [PCT_W-1:0]       PCT_FULL  = PCT_W'(100);
  localparam logic [PROD_W-1:0]      HALF_LSB  = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    REG_VALID_MIN  = 3'd0,
    REG_ZERO       = 3'd1,
    REG_FULL_SCALE = 3'd2,
    REG_VALID_MAX  = 3'd3,
    REG_FS_PRES    = 3'd4,
    REG_ALPHA      = 3'd5,
    REG_ON_THR     = 3'd6,
    REG_OFF_THR    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] valid_min;
    logic [SAMPLE_BITS-1:0] zero;
    logic [SAMPLE_BITS-1:0] full_scale;
    logic [SAMPLE_BITS-1:0] valid_max;
    logic [FSP_W-1:0]       fs_pressure;
    logic [ALPHA_W-1:0]     alpha_sat;
    logic [PCT_W-1:0]       on_thr;
    logic [PCT_W-1:0]       off_thr;
    logic                   calib_ok;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              wide;
    logic [DVD_W-1:0]  dividend;
    logic [FILT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/bpc_regs.sv -----
// ----------------------------------------------------------------------------
// bpc_regs
// APB register file with calibration ordering check.
// ----------------------------------------------------------------------------
module bpc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::DATA_W-1:0] pwdata,
  output logic [bpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bpc_pkg::cfg_t              cfg_o
);
  import bpc_pkg::*;

  logic [SAMPLE_BITS-1:0] valid_min_q, zero_q, full_scale_q, valid_max_q;
  logic [FSP_W-1:0]       fs_pres_q;
  logic [ALPHA_W-1:0]     alpha_q;
  logic [PCT_W-1:0]       on_thr_q, off_thr_q;
  reg_idx_e               idx;
  logic                   wr_en;

  assign idx   = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_min_q  <= SAMPLE_BITS'(100);
      zero_q       <= SAMPLE_BITS'(400);
      full_scale_q <= SAMPLE_BITS'(3700);
      valid_max_q  <= SAMPLE_BITS'(4000);
      fs_pres_q    <= FSP_W'(10000);
      alpha_q      <= ALPHA_ONE;
      on_thr_q     <= PCT_W'(10);
      off_thr_q    <= PCT_W'(5);
    end else if (wr_en) begin
      unique case (idx)
        REG_VALID_MIN:  valid_min_q  <= pwdata[SAMPLE_BITS-1:0];
        REG_ZERO:       zero_q       <= pwdata[SAMPLE_BITS-1:0];
        REG_FULL_SCALE: full_scale_q <= pwdata[SAMPLE_BITS-1:0];
        REG_VALID_MAX:  valid_max_q  <= pwdata[SAMPLE_BITS-1:0];
        REG_FS_PRES:    fs_pres_q    <= pwdata[FSP_W-1:0];
        REG_ALPHA:      alpha_q      <= pwdata[ALPHA_W-1:0];
        REG_ON_THR:     on_thr_q     <= pwdata[PCT_W-1:0];
        REG_OFF_THR:    off_thr_q    <= pwdata[PCT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VALID_MIN:  prdata = DATA_W'(valid_min_q);
      REG_ZERO:       prdata = DATA_W'(zero_q);
      REG_FULL_SCALE: prdata = DATA_W'(full_scale_q);
      REG_VALID_MAX:  prdata = DATA_W'(valid_max_q);
      REG_FS_PRES:    prdata = DATA_W'(fs_pres_q);
      REG_ALPHA:      prdata = DATA_W'(alpha_q);
      REG_ON_THR:     prdata = DATA_W'(on_thr_q);
      REG_OFF_THR:    prdata = DATA_W'(off_thr_q);
    endcase
  end

  always_comb begin
    cfg_o.valid_min   = valid_min_q;
    cfg_o.zero        = zero_q;
    cfg_o.full_scale  = full_scale_q;
    cfg_o.valid_max   = valid_max_q;
    cfg_o.fs_pressure = fs_pres_q;
    cfg_o.alpha_sat   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
    cfg_o.on_thr      = on_thr_q;
    cfg_o.off_thr     = off_thr_q;
    cfg_o.calib_ok    = (valid_min_q < zero_q) && (zero_q < full_scale_q) &&
                        (full_scale_q < valid_max_q) && (valid_max_q <= ADC_LIMIT) &&
                        (fs_pres_q != '0) && (off_thr_q < on_thr_q) &&
                        (on_thr_q <= PCT_FULL);
  end

endmodule

// ----- hdl/bpc_mul.sv -----
// ----------------------------------------------------------------------------
// bpc_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module bpc_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [bpc_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [bpc_pkg::MUL_B_W-1:0] b_i,
  output logic signed [bpc_pkg::PROD_W-1:0]  prod_o
);
  import bpc_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/bpc_div.sv -----
// ----------------------------------------------------------------------------
// bpc_div
// Restoring divider, one quotient bit per cycle, 7 or 16 quotient bits.
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpc_pkg::div_req_t req_i,
  output bpc_pkg::div_rsp_t rsp_o
);
  import bpc_pkg::*;

  logic [REM_W-1:0]  rem_q;
  logic [QUO_W-1:0]  lo_q;
  logic [QUO_W-1:0]  quo_q;
  logic [FILT_W-1:0] dsr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign trial = {rem_q[REM_W-2:0], lo_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.wide ? CNT_W'(QUO_W) : CNT_W'(NARROW_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dsr_q <= req_i.divisor;
      quo_q <= '0;
      if (req_i.wide) begin
        rem_q <= REM_W'(req_i.dividend[DVD_W-1:QUO_W]);
        lo_q  <= req_i.dividend[QUO_W-1:0];
      end else begin
        rem_q <= req_i.dividend[REM_W+NARROW_BITS-1:NARROW_BITS];
        lo_q  <= {req_i.dividend[NARROW_BITS-1:0], (QUO_W-NARROW_BITS)'(0)};
      end
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
      lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- hdl/brake_pressure_conditioner_core.sv -----
// ----------------------------------------------------------------------------
// brake_pressure_conditioner_core
// Sensor low-pass filter, normalization and hysteretic brake flag.
// ----------------------------------------------------------------------------
// a rejected sample goes from the check straight to output; a valid one runs
// check with filter multiply, filter update (skipped when it seeds), normalize,
// percent multiply, 7-bit divide, pressure multiply, 16-bit divide, then output
// a sample is taken only in idle, as the multiplier and divider are shared
// a new sample is taken while a finished result waits in the output register
// reset clears filter state, brake flag and sequencer; registers take defaults
module brake_pressure_conditioner_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bpc_pkg::SAMPLE_BITS-1:0]     raw_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                result_valid_o,
  output logic [bpc_pkg::PCT_W-1:0]           pressure_pct_o,
  output logic [bpc_pkg::FILT_W-1:0]          filtered_sample_o,
  output logic [bpc_pkg::PRES_W-1:0]          pressure_centibar_o,
  output logic                                brake_active_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]          paddr,
  input  logic [bpc_pkg::DATA_W-1:0]          pwdata,
  output logic [bpc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import bpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FUPD, S_NORM, S_PMUL, S_PDIV, S_PWAIT, S_RDIV, S_RWAIT, S_OUT
  } state_e;

  cfg_t                      cfg;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  state_e                 state_q;
  logic [SAMPLE_BITS-1:0] raw_q;
  logic                   seeded_q;
  logic [FILT_W-1:0]      filt_q;
  logic                   active_q;
  logic                   item_ok_q;
  logic [FILT_W-1:0]      num_q;
  logic [FILT_W-1:0]      den_q;
  logic [PCT_W-1:0]       pct_q;
  logic [PRES_W-1:0]      pres_q;
  logic                   out_valid_q;
  logic                   res_valid_q;
  logic [PCT_W-1:0]       res_pct_q;
  logic [FILT_W-1:0]      res_filt_q;
  logic [PRES_W-1:0]      res_pres_q;
  logic                   res_active_q;

  logic [FILT_W-1:0]      x_val;
  logic [FILT_W-1:0]      zero_fix;
  logic [FILT_W-1:0]      num_raw;
  logic [FILT_W-1:0]      den_val;
  logic signed [PROD_W-1:0] rnd;
  logic                   sample_ok;
  logic                   active_next;

  bpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign x_val     = {raw_q, FRAC_BITS'(0)};
  assign zero_fix  = {cfg.zero, FRAC_BITS'(0)};
  assign den_val   = {cfg.full_scale - cfg.zero, FRAC_BITS'(0)};
  assign num_raw   = (filt_q > zero_fix) ? (filt_q - zero_fix) : '0;
  assign sample_ok = cfg.calib_ok && (raw_q >= cfg.valid_min) && (raw_q <= cfg.valid_max);
  assign rnd       = prod + $signed(HALF_LSB);

  always_comb begin
    if (!active_q && (pct_q > cfg.on_thr)) begin
      active_next = 1'b1;
    end else if (active_q && (pct_q <= cfg.off_thr)) begin
      active_next = 1'b0;
    end else begin
      active_next = active_q;
    end
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = $signed({1'b0, x_val}) - $signed({1'b0, filt_q});
    mul_b  = $signed({1'b0, cfg.alpha_sat});
    unique case (state_q)
      S_CHECK: mul_en = 1'b1;
      S_PMUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, num_q});
        mul_b  = $signed(MUL_B_W'(PCT_FULL));
      end
      S_PWAIT: begin
        mul_en = div_rsp.done;
        mul_a  = $signed({1'b0, num_q});
        mul_b  = $signed(MUL_B_W'(cfg.fs_pressure));
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = (state_q == S_PDIV) || (state_q == S_RDIV);
    div_req.wide     = (state_q == S_RDIV);
    div_req.dividend = prod[DVD_W-1:0];
    div_req.divisor  = den_q;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      raw_q        <= '0;
      seeded_q     <= 1'b0;
      filt_q       <= '0;
      active_q     <= 1'b0;
      item_ok_q    <= 1'b0;
      num_q        <= '0;
      den_q        <= '0;
      pct_q        <= '0;
      pres_q       <= '0;
      out_valid_q  <= 1'b0;
      res_valid_q  <= 1'b0;
      res_pct_q    <= '0;
      res_filt_q   <= '0;
      res_pres_q   <= '0;
      res_active_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            raw_q   <= raw_sample_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          item_ok_q <= sample_ok;
          if (!sample_ok) begin
            seeded_q <= 1'b0;
            filt_q   <= '0;
            pct_q    <= '0;
            pres_q   <= '0;
            state_q  <= S_OUT;
          end else if (!seeded_q) begin
            seeded_q <= 1'b1;
            filt_q   <= x_val;
            state_q  <= S_NORM;
          end else begin
            state_q <= S_FUPD;
          end
        end
        S_FUPD: begin
          filt_q  <= filt_q + FILT_W'(rnd >>> FRAC_BITS);
          state_q <= S_NORM;
        end
        S_NORM: begin
          num_q   <= (num_raw > den_val) ? den_val : num_raw;
          den_q   <= den_val;
          state_q <= S_PMUL;
        end
        S_PMUL:  state_q <= S_PDIV;
        S_PDIV:  state_q <= S_PWAIT;
        S_PWAIT: begin
          if (div_rsp.done) begin
            pct_q   <= (div_rsp.quotient > QUO_W'(PCT_FULL)) ? PCT_FULL
                                                              : div_rsp.quotient[PCT_W-1:0];
            state_q <= S_RDIV;
          end
        end
        S_RDIV:  state_q <= S_RWAIT;
        S_RWAIT: begin
          if (div_rsp.done) begin
            pres_q  <= (div_rsp.quotient > cfg.fs_pressure) ? cfg.fs_pressure
                                                            : div_rsp.quotient;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            res_valid_q  <= item_ok_q;
            res_pct_q    <= pct_q;
            res_filt_q   <= filt_q;
            res_pres_q   <= pres_q;
            res_active_q <= item_ok_q & active_next;
            active_q     <= item_ok_q & active_next;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_valid_o      = res_valid_q;
  assign pressure_pct_o      = res_pct_q;
  assign filtered_sample_o   = res_filt_q;
  assign pressure_centibar_o = res_pres_q;
  assign brake_active_o      = res_active_q;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for brake_pressure_conditioner_core: samples go in over
// a valid/ready channel, calibration goes in over the APB port, and each
// result is compared field by field with an in-bench model of the filter,
// normalization and brake flag.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned END_SETTLE   = 60;

  typedef struct packed {
    logic              ok;
    logic [PCT_W-1:0]  pct;
    logic [FILT_W-1:0] filt;
    logic [PRES_W-1:0] pres;
    logic              active;
  } cond_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] raw_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   result_valid_o;
  logic [PCT_W-1:0]       pressure_pct_o;
  logic [FILT_W-1:0]      filtered_sample_o;
  logic [PRES_W-1:0]      pressure_centibar_o;
  logic                   brake_active_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  brake_pressure_conditioner_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .raw_sample_i        (raw_sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .result_valid_o      (result_valid_o),
    .pressure_pct_o      (pressure_pct_o),
    .filtered_sample_o   (filtered_sample_o),
    .pressure_centibar_o (pressure_centibar_o),
    .brake_active_o      (brake_active_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // calibration copy, reset values
  logic [SAMPLE_BITS-1:0] cal_vmin = 12'd100;
  logic [SAMPLE_BITS-1:0] cal_zero = 12'd400;
  logic [SAMPLE_BITS-1:0] cal_fs   = 12'd3700;
  logic [SAMPLE_BITS-1:0] cal_vmax = 12'd4000;
  logic [FSP_W-1:0]       cal_fsp  = 16'd10000;
  logic [ALPHA_W-1:0]     cal_alpha = ALPHA_ONE;
  logic [PCT_W-1:0]       cal_on   = 7'd10;
  logic [PCT_W-1:0]       cal_off  = 7'd5;

  // filter state
  bit                flt_seeded = 1'b0;
  logic [FILT_W-1:0] flt_value = '0;
  bit                brake_on = 1'b0;

  cond_result_t pending_results[$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned n_samples = 0;
  int unsigned n_results = 0;
  int unsigned n_rejected = 0;
  int unsigned n_active = 0;
  int unsigned n_cal_loads = 0;
  int unsigned tx_burst = 0;
  int unsigned rx_burst = 0;
  int unsigned rx_hold_req = 0;
  int          walk_level = 2000;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  function automatic cond_result_t condition_sample(logic [SAMPLE_BITS-1:0] raw);
    cond_result_t res;
    bit [63:0]    x, a, num, den, zq, pct, pres;
    bit           cal_good;
    res = '0;
    cal_good = cal_vmin < cal_zero && cal_zero < cal_fs && cal_fs < cal_vmax &&
               cal_vmax <= ADC_LIMIT && cal_fsp != 0 && cal_off < cal_on &&
               cal_on <= PCT_FULL;
    if (!cal_good || raw < cal_vmin || raw > cal_vmax) begin
      flt_seeded = 1'b0;
      flt_value  = '0;
      brake_on   = 1'b0;
      return res;
    end
    x = 64'(raw) << FRAC_BITS;
    if (!flt_seeded) begin
      flt_value  = x[FILT_W-1:0];
      flt_seeded = 1'b1;
    end else begin
      a = (cal_alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(cal_alpha);
      x = ((64'(ALPHA_ONE) - a) * 64'(flt_value) + a * x + 64'(HALF_LSB)) >> FRAC_BITS;
      flt_value = x[FILT_W-1:0];
    end
    zq  = 64'(cal_zero) << FRAC_BITS;
    num = (64'(flt_value) > zq) ? 64'(flt_value) - zq : 64'd0;
    den = (64'(cal_fs) - 64'(cal_zero)) << FRAC_BITS;
    if (num > den) num = den;
    pct  = (num * 64'(PCT_FULL)) / den;
    pres = (num * 64'(cal_fsp)) / den;
    if (pct > 64'(PCT_FULL)) pct = 64'(PCT_FULL);
    if (pres > 64'(cal_fsp)) pres = 64'(cal_fsp);
    if (!brake_on && pct > 64'(cal_on)) brake_on = 1'b1;
    else if (brake_on && pct <= 64'(cal_off)) brake_on = 1'b0;
    res.ok     = 1'b1;
    res.pct    = pct[PCT_W-1:0];
    res.filt   = flt_value;
    res.pres   = pres[PRES_W-1:0];
    res.active = brake_on;
    return res;
  endfunction

  // mostly short gaps, some long ones, now and then a burst with none
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 20);
    if (r < 97) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(40, 120);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int lo, hi;
    int unsigned r;
    lo = (cal_vmin < cal_vmax) ? int'(cal_vmin) : int'(cal_vmax);
    hi = (cal_vmin < cal_vmax) ? int'(cal_vmax) : int'(cal_vmin);
    r = $urandom_range(0, 99);
    if (r < 8) return SAMPLE_BITS'($urandom_range(0, ADC_LIMIT));
    if (r < 25) walk_level = $urandom_range(lo, hi);
    else walk_level += int'($urandom_range(0, 240)) - 120;
    if (walk_level < lo) walk_level = lo;
    if (walk_level > hi) walk_level = hi;
    return SAMPLE_BITS'(walk_level);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch %s: got %0d expected %0d (result %0d, cycle %0d)", what, got,
               want, n_results, cycle_count);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      pending_results.push_back(condition_sample(raw_sample_i));
  end

  always @(posedge clk_i) begin : check_results
    cond_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", result_valid_o, 0);
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (!want.ok) n_rejected++;
        if (want.active) n_active++;
        if (result_valid_o !== want.ok)
          report_mismatch("result_valid", result_valid_o, want.ok);
        if (pressure_pct_o !== want.pct)
          report_mismatch("pressure_pct", pressure_pct_o, want.pct);
        if (filtered_sample_o !== want.filt)
          report_mismatch("filtered_sample", filtered_sample_o, want.filt);
        if (pressure_centibar_o !== want.pres)
          report_mismatch("pressure_centibar", pressure_centibar_o, want.pres);
        if (brake_active_o !== want.active)
          report_mismatch("brake_active", brake_active_o, want.active);
      end
    end
  end

  // result side: random ready, with a long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req != 0) begin
        gap = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        gap = pick_gap(rx_burst);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    int unsigned       w;
    logic [DATA_W-1:0] bus;
    case (idx) inside
      REG_FS_PRES:             w = FSP_W;
      REG_ALPHA:               w = ALPHA_W;
      REG_ON_THR, REG_OFF_THR: w = PCT_W;
      default:                 w = SAMPLE_BITS;
    endcase
    bus = value | (DATA_W'($urandom) << w);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= bus;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VALID_MIN:  cal_vmin  = bus[SAMPLE_BITS-1:0];
      REG_ZERO:       cal_zero  = bus[SAMPLE_BITS-1:0];
      REG_FULL_SCALE: cal_fs    = bus[SAMPLE_BITS-1:0];
      REG_VALID_MAX:  cal_vmax  = bus[SAMPLE_BITS-1:0];
      REG_FS_PRES:    cal_fsp   = bus[FSP_W-1:0];
      REG_ALPHA:      cal_alpha = bus[ALPHA_W-1:0];
      REG_ON_THR:     cal_on    = bus[PCT_W-1:0];
      REG_OFF_THR:    cal_off   = bus[PCT_W-1:0];
      default:        ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_calibration(int unsigned vmin, int unsigned zero, int unsigned fs,
                                  int unsigned vmax, int unsigned fsp, int unsigned alpha,
                                  int unsigned on_pct, int unsigned off_pct);
    write_reg(REG_VALID_MIN, vmin);
    write_reg(REG_ZERO, zero);
    write_reg(REG_FULL_SCALE, fs);
    write_reg(REG_VALID_MAX, vmax);
    write_reg(REG_FS_PRES, fsp);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_ON_THR, on_pct);
    write_reg(REG_OFF_THR, off_pct);
    n_cal_loads++;
  endtask

  task automatic send_sample(logic [SAMPLE_BITS-1:0] raw, bit paced = 1'b1);
    int unsigned gap;
    gap = paced ? pick_gap(tx_burst) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    n_samples++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // reset calibration: seeding, window edges, clamp and hysteresis thresholds
  task automatic test_default_calibration();
    int unsigned levels[] = '{730, 764, 600, 565, 399, 3800, 4000, 4001, 100, 99, 4095};
    foreach (levels[i]) send_sample(SAMPLE_BITS'(levels[i]));
    wait_drained();
  endtask

  task automatic test_filter_weights();
    write_reg(REG_ALPHA, 32768);
    send_sample(12'd1000);
    send_sample(12'd3000);
    send_sample(12'd3000);
    wait_drained();
    write_reg(REG_ALPHA, 0);
    send_sample(12'd3900);
    wait_drained();
    write_reg(REG_ALPHA, 131071);
    send_sample(12'd200);
    wait_drained();
  endtask

  // ordering rules broken in turn, then widest and narrowest legal settings
  task automatic test_calibration_limits();
    int unsigned vmin, zero, fs, vmax, fsp, on_pct, off_pct;
    for (int k = 0; k < 7; k++) begin
      vmin = 100; zero = 400; fs = 3700; vmax = 4000; fsp = 10000; on_pct = 10; off_pct = 5;
      case (k)
        0: vmin = 400;
        1: fs = 400;
        2: vmax = 3700;
        3: fsp = 0;
        4: off_pct = 10;
        5: on_pct = 101;
        default: on_pct = 127;
      endcase
      load_calibration(vmin, zero, fs, vmax, fsp, 65536, on_pct, off_pct);
      send_sample(12'd2000);
      wait_drained();
    end
    load_calibration(0, 1, 4094, 4095, 65535, 65536, 100, 99);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4094);
    wait_drained();
    load_calibration(0, 1, 2, 4095, 1, 1, 1, 0);
    send_sample(12'd2);
    send_sample(12'd3);
    wait_drained();
  endtask

  task automatic test_output_stall();
    load_calibration(100, 400, 3700, 4000, 10000, 20000, 10, 5);
    rx_hold_req = STALL_CYCLES;
    repeat (24) send_sample(pick_sample(), 1'b0);
    wait_drained();
  endtask

  task automatic load_random_calibration();
    int unsigned vmin, zero, fs, vmax, fsp, alpha, on_pct, off_pct, r;
    vmin = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1200);
    zero = $urandom_range(vmin + 1, vmin + 1200);
    fs   = $urandom_range(zero + 1, ADC_LIMIT - 1);
    vmax = ($urandom_range(0, 7) == 0) ? ADC_LIMIT : $urandom_range(fs + 1, ADC_LIMIT);
    r = $urandom_range(0, 99);
    fsp = (r < 10) ? 65535 : (r < 15) ? 1 : $urandom_range(1, 65535);
    r = $urandom_range(0, 99);
    if (r < 15) alpha = ALPHA_ONE;
    else if (r < 25) alpha = $urandom_range(ALPHA_ONE + 1, 131071);
    else if (r < 32) alpha = $urandom_range(0, 3);
    else alpha = $urandom_range(0, ALPHA_ONE);
    on_pct  = $urandom_range(1, PCT_FULL);
    off_pct = $urandom_range(0, on_pct - 1);
    load_calibration(vmin, zero, fs, vmax, fsp, alpha, on_pct, off_pct);
    if ($urandom_range(0, 5) == 0)
      write_reg(reg_idx_e'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_len, sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      load_random_calibration();
      phase_len = $urandom_range(30, 90);
      repeat (phase_len) send_sample(pick_sample());
      sent += phase_len;
      wait_drained();
    end
  endtask

  initial begin : run_tests
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_calibration();
    test_filter_weights();
    test_calibration_limits();
    test_output_stall();
    test_random_traffic();
    wait_drained();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("tb: %0d samples sent, %0d results checked, %0d rejected, %0d with brake active",
             n_samples, n_results, n_rejected, n_active);
    $display("tb: %0d calibration loads incl. ordering faults, saturated alpha, long stall",
             n_cal_loads);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
